// File: hw/rtl/wmda_pkg.sv
`default_nettype none

package wmda_pkg;

   // widths of the request and response words
   localparam int WORD_W     = 32;
   localparam int MANT_W     = 3 * WORD_W;
   localparam int OPND_W     = 31;
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 136;

   // one cell per quotient bit
   localparam int CELLS = MANT_W;

   // largest exponent accepted in the flags word
   localparam logic [7:0] EXP_LIMIT = 8'd28;

   // request kinds carried on req_tuser
   localparam logic REQ_DIVIDE = 1'b0;
   localparam logic REQ_ADD    = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

   // what moves from one cell to the next
   typedef struct packed {
      logic                valid;
      logic                divide;
      logic [OPND_W-1:0]   divisor;
      logic [OPND_W-1:0]   rem;
      logic [MANT_W-1:0]   work;
      logic [1:0]          status;
      logic                flags_ok;
   } stage_type;

   // response word, lowest field in the lowest bits
   typedef struct packed {
      logic                flags_valid;
      logic [1:0]          status;
      logic [OPND_W-1:0]   remainder;
      logic [WORD_W-1:0]   res_high;
      logic [WORD_W-1:0]   res_mid;
      logic [WORD_W-1:0]   res_low;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/wmda_front.sv
`default_nettype none

// entry stage: flags check, the add, and divide-by-zero setup
module wmda_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          take,
   input  wire logic                          kind,
   input  wire logic [wmda_pkg::MANT_W-1:0]   mant,
   input  wire logic [wmda_pkg::OPND_W-1:0]   operand,
   input  wire logic [wmda_pkg::WORD_W-1:0]   flags_word,
   output wmda_pkg::stage_type                stage_out
);

   wmda_pkg::stage_type stage_ff;
   wmda_pkg::stage_type stage_in;
   logic [wmda_pkg::MANT_W:0] sum;
   logic flags_ok;

   always_comb begin
      flags_ok = (flags_word[15:0] == 16'd0) && (flags_word[30:24] == 7'd0)
                 && (flags_word[23:16] <= wmda_pkg::EXP_LIMIT);
      sum = {1'b0, mant} + {{(wmda_pkg::MANT_W - wmda_pkg::OPND_W + 1){1'b0}}, operand};

      stage_in          = '0;
      stage_in.valid    = take;
      stage_in.flags_ok = flags_ok;
      stage_in.divisor  = operand;
      if (kind == wmda_pkg::REQ_ADD) begin
         if (sum[wmda_pkg::MANT_W]) begin
            stage_in.status = wmda_pkg::STATUS_OVERFLOW;
         end else begin
            stage_in.work   = sum[wmda_pkg::MANT_W-1:0];
         end
      end else if (operand == '0) begin
         stage_in.status = wmda_pkg::STATUS_DIV_ZERO;
      end else begin
         stage_in.divide = 1'b1;
         stage_in.work   = mant;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.divide   <= stage_in.divide;
         stage_ff.divisor  <= stage_in.divisor;
         stage_ff.rem      <= stage_in.rem;
         stage_ff.work     <= stage_in.work;
         stage_ff.status   <= stage_in.status;
         stage_ff.flags_ok <= stage_in.flags_ok;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// File: hw/rtl/wmda_cell.sv
`default_nettype none

// one restoring-division step: brings down one dividend bit, yields one quotient bit
module wmda_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire wmda_pkg::stage_type stage_in,
   output wmda_pkg::stage_type      stage_out
);

   wmda_pkg::stage_type stage_ff;
   wmda_pkg::stage_type next_in;
   logic [wmda_pkg::OPND_W:0] partial;
   logic [wmda_pkg::OPND_W:0] diff;
   logic                      fits;

   always_comb begin
      partial = {stage_in.rem, stage_in.work[wmda_pkg::MANT_W-1]};
      diff    = partial - {1'b0, stage_in.divisor};
      fits    = partial >= {1'b0, stage_in.divisor};
      next_in = stage_in;
      if (stage_in.divide) begin
         next_in.rem  = fits ? diff[wmda_pkg::OPND_W-1:0] : partial[wmda_pkg::OPND_W-1:0];
         next_in.work = {stage_in.work[wmda_pkg::MANT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= next_in.valid;
      end
      if (advance) begin
         stage_ff.divide   <= next_in.divide;
         stage_ff.divisor  <= next_in.divisor;
         stage_ff.rem      <= next_in.rem;
         stage_ff.work     <= next_in.work;
         stage_ff.status   <= next_in.status;
         stage_ff.flags_ok <= next_in.flags_ok;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// File: hw/rtl/wmda_out_buf.sv
`default_nettype none

// output register plus skid entry; the chain moves only while the skid is empty
module wmda_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wmda_pkg::stage_type tail,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output wmda_pkg::result_type     rsp_result,
   output logic                     advance
);

   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   wmda_pkg::result_type out_data_ff;
   wmda_pkg::result_type skid_data_ff;
   wmda_pkg::result_type tail_result;
   logic                 pop;

   always_comb begin
      tail_result.flags_valid = tail.flags_ok;
      tail_result.status      = tail.status;
      tail_result.remainder   = tail.rem;
      tail_result.res_high    = tail.work[3*wmda_pkg::WORD_W-1:2*wmda_pkg::WORD_W];
      tail_result.res_mid     = tail.work[2*wmda_pkg::WORD_W-1:wmda_pkg::WORD_W];
      tail_result.res_low     = tail.work[wmda_pkg::WORD_W-1:0];
   end

   assign pop     = out_valid_ff && rsp_tready;
   assign advance = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (tail.valid) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= tail_result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= tail_result;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/wide_mantissa_divide_add.sv
// channel    dir  tdata fields (low bit up)                              tuser
// req_       in   mant_low, mant_mid, mant_high, operand, flags_word     req_type
// rsp_       out  res_low, res_mid, res_high, remainder, status,         -
//                 flags_valid
//
// one request per cycle sustained while rsp_tready stays high; between the accepting edge and
// rsp_tvalid lie the entry stage, which loads at that edge, then 96 division cells (one
// quotient bit per cell) and one output register
// reset clears the valid bits of every stage and of the output side
// when rsp_tready is low the output register holds, the next result lands in a skid
// entry, and then req_tready drops and the whole cell chain freezes until it drains
`default_nettype none

module wide_mantissa_divide_add (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request side
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // mant_low [31:0], mant_mid [63:32], mant_high [95:64], operand [126:96],
   // flags_word [158:127], zero [159]
   input  wire logic [wmda_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type [0]: divide or add
   input  wire logic                              req_tuser,
   // response side
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // res_low [31:0], res_mid [63:32], res_high [95:64], remainder [126:96],
   // status [128:127], flags_valid [129], zero [135:130]
   output logic [wmda_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   // every stage moves together; only the skid entry can stop the chain
   logic                 advance;
   logic                 take;
   wmda_pkg::stage_type  chain [0:wmda_pkg::CELLS];
   wmda_pkg::result_type rsp_result;

   assign req_tready = advance;
   assign take       = req_tvalid && advance;

   // entry: flags check, full 96-bit add, divide-by-zero setup
   wmda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .take       (take),
      .kind       (req_tuser),
      .mant       (req_tdata[wmda_pkg::MANT_W-1:0]),
      .operand    (req_tdata[wmda_pkg::MANT_W+wmda_pkg::OPND_W-1:wmda_pkg::MANT_W]),
      .flags_word (req_tdata[wmda_pkg::MANT_W+wmda_pkg::OPND_W+wmda_pkg::WORD_W-1:
                             wmda_pkg::MANT_W+wmda_pkg::OPND_W]),
      .stage_out  (chain[0])
   );

   // long division, most significant dividend bit first; add and error
   // results pass through the chain untouched
   for (genvar i = 0; i < wmda_pkg::CELLS; i++) begin : g_cell
      wmda_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // output register and skid
   wmda_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .tail       (chain[wmda_pkg::CELLS]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_result (rsp_result),
      .advance    (advance)
   );

   assign rsp_tdata = {{(wmda_pkg::RSP_DATA_W - $bits(wmda_pkg::result_type)){1'b0}},
                       rsp_result};

endmodule

`default_nettype wire

// File: hw/rtl/wmda_checker.sv
`default_nettype none

module wmda_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [wmda_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [wmda_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   wmda_pkg::result_type res;
   assign res = rsp_tdata[$bits(wmda_pkg::result_type)-1:0];

   // no response right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled response keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // error results carry zero words
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (res.status == wmda_pkg::STATUS_OVERFLOW ||
                     res.status == wmda_pkg::STATUS_DIV_ZERO)
      |-> res.res_low == '0 && res.res_mid == '0 && res.res_high == '0)
      else $error("error status with nonzero result");

   // status code range and divide-by-zero remainder
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> res.status != 2'd3 &&
                     (res.status != wmda_pkg::STATUS_DIV_ZERO || res.remainder == '0))
      else $error("bad status or remainder");

endmodule

bind wide_mantissa_divide_add wmda_checker u_checker (.*);

`default_nettype wire

// File: tb/sv/tb_wide_mantissa_divide_add.sv
`default_nettype none

module tb_wide_mantissa_divide_add;
   timeunit 1ns;
   timeprecision 1ps;

   // rough depth of the block: entry stage, 96 cells, output register, skid
   localparam int PIPE_DEPTH  = 110;
   // generous ceiling on the whole run
   localparam int CYCLE_LIMIT = 200000;
   // no idling on either side once this close to the end
   localparam int QUIET_TAIL  = 80;
   // length of the one long receiver stall
   localparam int LONG_HOLD   = 400;

   // one request as the testbench sees it
   typedef struct {
      logic                          kind;
      logic [wmda_pkg::WORD_W-1:0]   mant_low;
      logic [wmda_pkg::WORD_W-1:0]   mant_mid;
      logic [wmda_pkg::WORD_W-1:0]   mant_high;
      logic [wmda_pkg::OPND_W-1:0]   operand;
      logic [wmda_pkg::WORD_W-1:0]   flags_word;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // block inputs, all known from time zero
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [wmda_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                              req_tuser  = wmda_pkg::REQ_DIVIDE;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [wmda_pkg::RSP_DATA_W-1:0]   rsp_tdata;

   // requests not yet offered, and results still owed by the block
   request_type            request_queue[$];
   wmda_pkg::result_type   pending_results[$];
   request_type            on_bus;

   int total_requests = 0;
   int requests_taken = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   int errors         = 0;
   int cycles         = 0;
   int send_idle      = 0;
   int hold_left      = 0;
   bit long_hold_done = 1'b0;

   // coverage tallies for the summary
   int n_divide = 0, n_add = 0, n_div_zero = 0, n_overflow = 0, n_bad_flags = 0;

   wide_mantissa_divide_add uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // single reset pulse at the start
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_results.size());
         $display("FAIL");
         $finish;
      end
   end

   // expected result of one request: 96-bit quotient and remainder, or sum (overflow on carry out)
   function automatic wmda_pkg::result_type mantissa_result(request_type r);
      wmda_pkg::result_type              res;
      logic [wmda_pkg::MANT_W-1:0]       mant;
      logic [wmda_pkg::MANT_W-1:0]       divisor;
      logic [wmda_pkg::MANT_W-1:0]       rem_wide;
      logic [wmda_pkg::MANT_W:0]         total;
      logic [7:0]                        expo;
      res  = '0;
      mant = {r.mant_high, r.mant_mid, r.mant_low};
      res.status = wmda_pkg::STATUS_OK;
      if (r.kind == wmda_pkg::REQ_DIVIDE) begin
         if (r.operand == '0) begin
            res.status = wmda_pkg::STATUS_DIV_ZERO;
         end else begin
            divisor  = {{(wmda_pkg::MANT_W-wmda_pkg::OPND_W){1'b0}}, r.operand};
            {res.res_high, res.res_mid, res.res_low} = mant / divisor;
            rem_wide = mant % divisor;
            res.remainder = rem_wide[wmda_pkg::OPND_W-1:0];
         end
      end else begin
         total = {1'b0, mant} +
                 {{(wmda_pkg::MANT_W+1-wmda_pkg::OPND_W){1'b0}}, r.operand};
         // carry out of the top word wipes the sum
         if (total[wmda_pkg::MANT_W])
            res.status = wmda_pkg::STATUS_OVERFLOW;
         else
            {res.res_high, res.res_mid, res.res_low} = total[wmda_pkg::MANT_W-1:0];
      end
      // sign bit is free, bits 0..15 and 24..30 must be clear, exponent capped
      expo = r.flags_word[23:16];
      res.flags_valid = (r.flags_word[15:0] == '0) && (r.flags_word[30:24] == '0) &&
                        (expo <= wmda_pkg::EXP_LIMIT);
      return res;
   endfunction

   task automatic queue_request(logic kind, logic [31:0] lo, logic [31:0] mid,
                                logic [31:0] hi, logic [30:0] opnd, logic [31:0] flags);
      request_type r;
      r.kind       = kind;
      r.mant_low   = lo;
      r.mant_mid   = mid;
      r.mant_high  = hi;
      r.operand    = opnd;
      r.flags_word = flags;
      request_queue.push_back(r);
   endtask

   // mantissa word with extra weight on zero, all ones and small values
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(0, 1000);
         default: return $urandom;
      endcase
   endfunction

   task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %h, got %h", results_seen,
                     name, want, got);
      end
   endtask

   // fill the request queue: directed corners first, then random traffic
   initial begin
      logic        kind;
      logic [31:0] lo, mid, hi, flags, raw;
      logic [30:0] opnd;

      // divide corners
      queue_request(wmda_pkg::REQ_DIVIDE, '1, '1, '1, 31'd1, 32'h0000_0000);
      queue_request(wmda_pkg::REQ_DIVIDE, '1, '1, '1, '1, 32'h001C_0000);
      queue_request(wmda_pkg::REQ_DIVIDE, $urandom, $urandom, $urandom, '0, 32'h0000_0000);
      queue_request(wmda_pkg::REQ_DIVIDE, '0, '0, '0, 31'd7, 32'h8000_0000);
      queue_request(wmda_pkg::REQ_DIVIDE, 32'd5, '0, '0, 31'd1000, 32'h0000_0000);
      queue_request(wmda_pkg::REQ_DIVIDE, $urandom, '0, 32'h0000_0001, '1, 32'h0000_0000);
      queue_request(wmda_pkg::REQ_DIVIDE, '1, '1, '1, '0, 32'hFFFF_FFFF);
      // add corners: plain, full carry ripple, overflow, max addend
      queue_request(wmda_pkg::REQ_ADD, '0, '0, '0, '0, 32'h0000_0000);
      queue_request(wmda_pkg::REQ_ADD, '1, '1, 32'h0000_0000, 31'd1, 32'h0000_0000);
      queue_request(wmda_pkg::REQ_ADD, '1, '1, '1, 31'd1, 32'h0000_0000);
      queue_request(wmda_pkg::REQ_ADD, '1, '1, '1, '0, 32'h0000_0000);
      queue_request(wmda_pkg::REQ_ADD, 32'h8000_0000, '1, '1, '1, 32'h0000_0000);
      queue_request(wmda_pkg::REQ_ADD, 32'h8000_0001, '1, '1, '1, 32'h0000_0000);
      queue_request(wmda_pkg::REQ_ADD, '0, '0, '0, '1, 32'h0000_0000);
      // flags word checks
      queue_request(wmda_pkg::REQ_ADD, $urandom, $urandom, 32'h0, 31'd3, 32'h001C_0000);
      queue_request(wmda_pkg::REQ_ADD, $urandom, $urandom, 32'h0, 31'd3, 32'h001D_0000);
      queue_request(wmda_pkg::REQ_DIVIDE, $urandom, $urandom, $urandom, 31'd3, 32'h00FF_0000);
      queue_request(wmda_pkg::REQ_DIVIDE, $urandom, $urandom, $urandom, 31'd9, 32'h0000_0001);
      queue_request(wmda_pkg::REQ_DIVIDE, $urandom, $urandom, $urandom, 31'd9, 32'h0000_8000);
      queue_request(wmda_pkg::REQ_ADD, $urandom, $urandom, 32'h0, 31'd9, 32'h0100_0000);
      queue_request(wmda_pkg::REQ_ADD, $urandom, $urandom, 32'h0, 31'd9, 32'h4000_0000);
      queue_request(wmda_pkg::REQ_DIVIDE, $urandom, $urandom, $urandom, 31'd11, 32'h801C_0000);

      for (int i = 0; i < 600; i++) begin
         kind = 1'($urandom_range(0, 1));
         lo   = pick_word();
         mid  = pick_word();
         hi   = pick_word();
         // sums near the top so that overflow and its near misses show up
         if (kind == wmda_pkg::REQ_ADD && $urandom_range(0, 9) == 0) begin
            hi  = '1;
            mid = '1;
            lo  = 32'hFFFF_FFFF - $urandom_range(0, 32'h7FFF_FFFF);
         end
         raw = $urandom;
         case ($urandom_range(0, 11))
            0:       opnd = '0;
            1:       opnd = '1;
            2:       opnd = 31'd1;
            3, 4:    opnd = 31'($urandom_range(1, 255));
            5:       opnd = 31'($urandom_range(1, 65535));
            default: opnd = raw[30:0];
         endcase
         // mostly well-formed flags, the rest broken in various ways
         raw = $urandom;
         if ($urandom_range(0, 3) != 0) begin
            flags = {raw[31], 7'd0, 8'($urandom_range(0, 28)), 16'd0};
         end else begin
            case ($urandom_range(0, 2))
               0:       flags = raw;
               1:       flags = {raw[31], 7'd0, 8'($urandom_range(29, 255)), 16'd0};
               default: flags = 32'd1 << $urandom_range(0, 30);
            endcase
         end
         queue_request(kind, lo, mid, hi, opnd, flags);
      end
      total_requests = request_queue.size();
   end

   // request driver: pops the queue, holds a request until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_idle  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            requests_taken++;
            pending_results.push_back(mantissa_result(on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (send_idle > 0) begin
               req_tvalid <= 1'b0;
               send_idle--;
            end else if (request_queue.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (request_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
               // start an idle burst
               req_tvalid <= 1'b0;
               send_idle  = $urandom_range(0, 8);
            end else begin
               on_bus     <= request_queue[0];
               req_tvalid <= 1'b1;
               req_tuser  <= request_queue[0].kind;
               req_tdata  <= {1'b0, request_queue[0].flags_word, request_queue[0].operand,
                              request_queue[0].mant_high, request_queue[0].mant_mid,
                              request_queue[0].mant_low};
               void'(request_queue.pop_front());
            end
         end
      end
   end

   // response monitor and receiver backpressure
   always @(posedge clock) begin
      wmda_pkg::result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(wmda_pkg::result_type)-1:0];
            results_seen++;
            if (pending_results.size() == 0) begin
               errors++;
               $display("result %0d arrived with nothing expected: %h", results_seen, got);
            end else begin
               want = pending_results.pop_front();
               if (want.status == wmda_pkg::STATUS_DIV_ZERO) n_div_zero++;
               if (want.status == wmda_pkg::STATUS_OVERFLOW) n_overflow++;
               if (!want.flags_valid) n_bad_flags++;
               note_field("res_low", want.res_low, got.res_low);
               note_field("res_mid", want.res_mid, got.res_mid);
               note_field("res_high", want.res_high, got.res_high);
               note_field("remainder", 32'(want.remainder), 32'(got.remainder));
               note_field("status", 32'(want.status), 32'(got.status));
               note_field("flags_valid", 32'(want.flags_valid), 32'(got.flags_valid));
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!long_hold_done && results_seen >= 100) begin
            // one long stall so the cell chain fills and req_tready drops
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            hold_left  = LONG_HOLD - 1;
         end else if (results_seen < total_requests - QUIET_TAIL &&
                      $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            hold_left  = $urandom_range(0, 8);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // request mix, counted as requests are taken
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         if (on_bus.kind == wmda_pkg::REQ_DIVIDE) n_divide++;
         else n_add++;
      end
   end

   // end of run: all requests taken, all results drained, then a quiet tail
   initial begin
      @(negedge reset);
      while (total_requests == 0 || requests_taken < total_requests) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("%0d expected results never arrived", pending_results.size());
      end
      $display("covered %0d divides (%0d by zero) and %0d adds (%0d overflowing)",
               n_divide, n_div_zero, n_add, n_overflow);
      $display("%0d results checked, %0d with bad flags, %0d field mismatches",
               results_seen, n_bad_flags, mismatches);
      if (errors == 0 && mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/wmda_pkg.sv
hw/rtl/wmda_front.sv
hw/rtl/wmda_cell.sv
hw/rtl/wmda_out_buf.sv
hw/rtl/wide_mantissa_divide_add.sv
hw/rtl/wmda_checker.sv
tb/sv/tb_wide_mantissa_divide_add.sv
